@@ src/lph_pkg.sv @@
// Shared types and constants for the linear probing hash table.
// No dependencies; imported by every module of the block except lph_ram.
package lph_pkg;

    localparam int SLOTS_DEF   = 256;
    localparam int KEY_W       = 32;
    localparam int HASH_W      = 32;
    localparam int VAL_W       = 64;
    localparam int MASK_W      = 8;
    localparam int CNT_W       = 9;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int KIND_W      = 2;
    localparam int QDEPTH      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_FIELDS_W = OP_W + KEY_W + HASH_W + VAL_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = STAT_W + 1 + VAL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int ENTRY_W     = KIND_W + KEY_W + VAL_W;

    localparam logic [OP_W-1:0] OP_GET = 2'd0;
    localparam logic [OP_W-1:0] OP_SET = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOMB  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT = 1'b1;

    localparam logic [MASK_W-1:0] SIZE_MASK_RST = 8'd255;
    localparam logic [MASK_W-1:0] MAX_COUNT_RST = 8'd192;

    typedef enum logic [1:0] {
        CMD_GET,
        CMD_SET,
        CMD_DEL,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [KEY_W-1:0]      key;
        logic [VAL_W-1:0]      value;
    } cmd_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } bk_ctl_t;

endpackage

@@ src/lph_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/lph_front.sv @@
// Front end: takes input words, decodes the operation, works out the home slot
// and holds commands in a two-entry queue for the back end. Depends on lph_pkg.
module lph_front
    import lph_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_TDATA_W-1:0]    s_tdata,
    input  logic [MASK_W-1:0]        size_mask,
    input  bk_ctl_t                  bk_ctl,
    output logic                     q_valid,
    output cmd_t                     q_cmd,
    output logic [$clog2(SLOTS)-1:0] q_idx
);

    localparam int IDX_W = $clog2(SLOTS);

    cmd_t             cmd_q   [QDEPTH];
    logic [IDX_W-1:0] idx_q   [QDEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    logic [OP_W-1:0]   in_op;
    logic [KEY_W-1:0]  in_key;
    logic [HASH_W-1:0] in_hash;
    logic [VAL_W-1:0]  in_value;
    logic [31:0]       home_masked;
    cmd_t              in_cmd;
    logic              push;
    logic              pop;

    assign in_op    = s_tdata[OP_W-1:0];
    assign in_key   = s_tdata[OP_W +: KEY_W];
    assign in_hash  = s_tdata[OP_W+KEY_W +: HASH_W];
    assign in_value = s_tdata[OP_W+KEY_W+HASH_W +: VAL_W];

    assign home_masked = in_hash & {{(32-MASK_W){1'b0}}, size_mask};

    always_comb
    begin
        in_cmd.key   = in_key;
        in_cmd.value = in_value;
        case (in_op)
            OP_GET:  in_cmd.kind = CMD_GET;
            OP_SET:  in_cmd.kind = CMD_SET;
            OP_DEL:  in_cmd.kind = CMD_DEL;
            default: in_cmd.kind = CMD_NOP;
        endcase
    end

    assign s_tready = (count_reg != 2'(QDEPTH)) && !bk_ctl.clearing;
    assign push     = s_tvalid && s_tready;
    assign pop      = bk_ctl.pop;

    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = cmd_q[rd_ptr_reg];
    assign q_idx   = idx_q[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_q[wr_ptr_reg] <= in_cmd;
            idx_q[wr_ptr_reg] <= home_masked[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ src/lph_back.sv @@
// Back end: clears the slot store after reset, walks the probe chain one slot
// a cycle, updates the store and holds the result word. Depends on lph_pkg, lph_ram.
module lph_back
    import lph_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [MASK_W-1:0]        size_mask,
    input  logic [MASK_W-1:0]        max_count,
    input  logic                     q_valid,
    input  cmd_t                     q_cmd,
    input  logic [$clog2(SLOTS)-1:0] q_idx,
    output bk_ctl_t                  bk_ctl,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   clr_idx_reg;
    cmd_t               cmd_reg;
    logic [IDX_W-1:0]   cur_idx_reg;
    logic [IDX_W-1:0]   step_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [VAL_W-1:0]   hit_val_reg;
    logic               have_empty_reg;
    logic [IDX_W-1:0]   empty_idx_reg;
    logic               have_tomb_reg;
    logic [IDX_W-1:0]   tomb_idx_reg;
    logic [CNT_W-1:0]   used_reg;
    logic               m_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic               is_new_reg;
    logic [VAL_W-1:0]   vout_reg;

    logic [ENTRY_W-1:0] rdata;
    logic [KIND_W-1:0]  rd_kind;
    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic [31:0]        step_masked;
    logic [IDX_W-1:0]   nxt_idx;
    logic [IDX_W-1:0]   raddr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               is_empty;
    logic               is_tomb;
    logic               is_hit;
    logic               probe_stop;
    logic               out_free;
    logic               do_finish;
    logic               pop;
    logic               room;
    logic [STAT_W-1:0]  res_status;
    logic               res_is_new;
    logic [VAL_W-1:0]   res_vout;
    logic               res_inc;

    lph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_kind = rdata[ENTRY_W-1 -: KIND_W];
    assign rd_key  = rdata[VAL_W +: KEY_W];
    assign rd_val  = rdata[VAL_W-1:0];

    assign step_masked = (32'(cur_idx_reg) + 32'd1) & {{(32-MASK_W){1'b0}}, size_mask};
    assign nxt_idx     = step_masked[IDX_W-1:0];
    assign raddr       = (state_reg == S_IDLE) ? q_idx : nxt_idx;

    assign is_empty   = (rd_kind == KIND_EMPTY);
    assign is_tomb    = (rd_kind == KIND_TOMB);
    assign is_hit     = (rd_kind == KIND_KEY) && (rd_key == cmd_reg.key);
    assign probe_stop = is_empty || is_hit || (step_reg == LAST_IDX);

    assign out_free  = !m_valid_reg || m_tready;
    assign do_finish = (state_reg == S_FINISH) && out_free;
    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign room      = ({1'b0, used_reg} + (CNT_W+1)'(1)) <= (CNT_W+1)'(max_count);

    assign bk_ctl.pop      = pop;
    assign bk_ctl.clearing = (state_reg == S_CLEAR);

    // outcome of the finished probe and the store update it causes; in S_CLEAR, the clearing write
    always_comb
    begin
        res_status = STAT_MISSING;
        res_is_new = 1'b0;
        res_vout   = '0;
        res_inc    = 1'b0;
        we         = 1'b0;
        waddr      = hit_idx_reg;
        wdata      = {KIND_KEY, cmd_reg.key, cmd_reg.value};
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_idx_reg;
            wdata = {KIND_EMPTY, {(KEY_W+VAL_W){1'b0}}};
        end
        else
        begin
            case (cmd_reg.kind)
                CMD_GET:
                begin
                    if (found_reg)
                    begin
                        res_status = STAT_OK;
                        res_vout   = hit_val_reg;
                    end
                end
                CMD_SET:
                begin
                    if (found_reg)
                    begin
                        res_status = STAT_OK;
                        we         = do_finish;
                    end
                    else if (have_tomb_reg)
                    begin
                        res_status = STAT_OK;
                        res_is_new = 1'b1;
                        we         = do_finish;
                        waddr      = tomb_idx_reg;
                    end
                    else if (have_empty_reg && room)
                    begin
                        res_status = STAT_OK;
                        res_is_new = 1'b1;
                        res_inc    = 1'b1;
                        we         = do_finish;
                        waddr      = empty_idx_reg;
                    end
                    else
                    begin
                        res_status = STAT_FULL;
                    end
                end
                CMD_DEL:
                begin
                    if (found_reg)
                    begin
                        res_status = STAT_OK;
                        we         = do_finish;
                        wdata      = {KIND_TOMB, cmd_reg.key, hit_val_reg};
                    end
                end
                default:
                begin
                    res_status = STAT_MISSING;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            used_reg       <= '0;
            m_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            have_empty_reg <= 1'b0;
            have_tomb_reg  <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && !do_finish)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                    if (clr_idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop)
                    begin
                        cmd_reg        <= q_cmd;
                        cur_idx_reg    <= q_idx;
                        step_reg       <= '0;
                        found_reg      <= 1'b0;
                        have_empty_reg <= 1'b0;
                        have_tomb_reg  <= 1'b0;
                        state_reg      <= (q_cmd.kind == CMD_NOP) ? S_FINISH : S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    if (is_tomb && !have_tomb_reg)
                    begin
                        have_tomb_reg <= 1'b1;
                        tomb_idx_reg  <= cur_idx_reg;
                    end
                    if (is_empty)
                    begin
                        have_empty_reg <= 1'b1;
                        empty_idx_reg  <= cur_idx_reg;
                    end
                    if (is_hit)
                    begin
                        found_reg   <= 1'b1;
                        hit_idx_reg <= cur_idx_reg;
                        hit_val_reg <= rd_val;
                    end
                    if (probe_stop)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        cur_idx_reg <= nxt_idx;
                        step_reg    <= step_reg + IDX_W'(1);
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        status_reg  <= res_status;
                        is_new_reg  <= res_is_new;
                        vout_reg    <= res_vout;
                        if (res_inc)
                        begin
                            used_reg <= used_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, vout_reg, is_new_reg, status_reg};

endmodule

@@ src/linear_probe_hash_table.sv @@
// Top level of the linear probing hash table: configuration registers,
// front end queue and probe back end. Depends on lph_pkg, lph_front, lph_back.
//
//  channel   dir  handshake            contents
//  s_axis    in   s_tvalid/s_tready    op, key_id, key_hash, value_in
//  m_axis    out  m_tvalid/m_tready    status, is_new, value_out
//  cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data (size_mask, max_count)
//
// After reset the slot store is swept clear, slot by slot, with s_tready low.
// An operation probes n slots from its home slot (1 to SLOTS, none for an unknown op):
// the single read port of the slot RAM examines one slot a cycle.
// Up to two words queue ahead of the probe engine; a result waits in the
// output register while the next probe runs.
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // op[1:0], key_id[33:2], key_hash[65:34], value_in[129:66]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status[1:0], is_new[2], value_out[66:3]
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [MASK_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(SLOTS);

    logic [MASK_W-1:0] size_mask_reg;
    logic [MASK_W-1:0] max_count_reg;
    bk_ctl_t           bk_ctl;
    logic              q_valid;
    cmd_t              q_cmd;
    logic [IDX_W-1:0]  q_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_mask_reg <= SIZE_MASK_RST;
            max_count_reg <= MAX_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SIZE_MASK: size_mask_reg <= cfg_data;
                REG_MAX_COUNT: max_count_reg <= cfg_data;
                default:       size_mask_reg <= size_mask_reg;
            endcase
        end
    end

    lph_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .size_mask (size_mask_reg),
        .bk_ctl    (bk_ctl),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_idx     (q_idx)
    );

    lph_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .size_mask (size_mask_reg),
        .max_count (max_count_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_idx     (q_idx),
        .bk_ctl    (bk_ctl),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
